// File: hdl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants of the multi-channel timer table.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_OUT       = 16;
  localparam logic [15:0] TPS_RESET = 16'd1000;

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_KILL  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_SET_OK    = 3'd0,
    ST_FULL      = 3'd1,
    ST_KILLED    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE_DUE  = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    SK_MATCH = 2'd0,
    SK_DUE   = 2'd1,
    SK_PICK  = 2'd2
  } scan_kind_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] period;
    logic [31:0] last_time;
    logic [15:0] repeats;
  } slot_t;

  typedef struct packed {
    logic       accept;
    logic       advance;
    logic       scan_start;
    scan_kind_t scan_kind;
    logic       do_set;
    logic       do_kill;
    logic       do_clear;
    logic       do_fire;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic fire_last;
  } dp_sts_t;

endpackage

// File: hdl/multi_timer_table.sv
// ----------------------------------------------------------------------------
// multi_timer_table
// Table of periodic timers keyed by id: set, kill, kill-all and tick.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every walk over the
// table reads the slot memory one slot a cycle; a set or kill takes one walk
// before it commits, and a kill-all commits without a walk. A tick takes
// one walk to mark the due timers and then one walk and a fire step per
// fired timer, at least one, to pick and fire the lowest id. Results appear
// on out_* for exactly one cycle each, marked by out_valid, with out_last on
// the final one of a command; there is no back-pressure, so the receiver must
// capture every beat as it comes.
// ----------------------------------------------------------------------------
module multi_timer_table import mtt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_timer_id,
  input  logic [15:0] in_period_seconds,
  input  logic [15:0] in_repeat_count,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_timer_id_res,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_ticks_per_second
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  mtt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_timer_id          (in_timer_id),
    .in_period_seconds    (in_period_seconds),
    .in_repeat_count      (in_repeat_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ticks_per_second (cfg_ticks_per_second),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_timer_id_res     (out_timer_id_res),
    .out_last             (out_last)
  );

endmodule

// File: hdl/mtt_ctrl.sv
// ----------------------------------------------------------------------------
// mtt_ctrl
// Sequencer of the timer table: walks scans and commits for each command.
// ----------------------------------------------------------------------------
module mtt_ctrl import mtt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_action,
  input  dp_sts_t     sts,
  output dp_cmd_t     cmd,
  output logic        busy
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SCAN_SET  = 9'b000000010,
    S_SCAN_KILL = 9'b000000100,
    S_SET       = 9'b000001000,
    S_KILL      = 9'b000010000,
    S_CLEAR     = 9'b000100000,
    S_DUE       = 9'b001000000,
    S_PICK      = 9'b010000000,
    S_FIRE      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.scan_kind = SK_MATCH;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (action_t'(in_action))
            ACT_SET: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN_SET;
            end
            ACT_KILL: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN_KILL;
            end
            ACT_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            ACT_TICK: begin
              cmd.advance    = 1'b1;
              cmd.scan_start = 1'b1;
              cmd.scan_kind  = SK_DUE;
              state_nxt      = S_DUE;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_SET: begin
        if (sts.scan_done) begin
          state_nxt = S_SET;
        end
      end
      S_SCAN_KILL: begin
        if (sts.scan_done) begin
          state_nxt = S_KILL;
        end
      end
      S_SET: begin
        cmd.do_set = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_KILL: begin
        cmd.do_kill = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_CLEAR: begin
        cmd.do_clear = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DUE: begin
        if (sts.scan_done) begin
          cmd.scan_start = 1'b1;
          cmd.scan_kind  = SK_PICK;
          state_nxt      = S_PICK;
        end
      end
      S_PICK: begin
        if (sts.scan_done) begin
          state_nxt = S_FIRE;
        end
      end
      S_FIRE: begin
        cmd.do_fire = 1'b1;
        // keep picking the next lowest id while more timers are due and the firing limit is not reached
        if (sts.best_found && !sts.fire_last) begin
          cmd.scan_start = 1'b1;
          cmd.scan_kind  = SK_PICK;
          state_nxt      = S_PICK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hdl/mtt_datapath.sv
// ----------------------------------------------------------------------------
// mtt_datapath
// Slot memory, valid and due flags, time counter, scan unit and result regs.
// ----------------------------------------------------------------------------
module mtt_datapath import mtt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [15:0] in_timer_id,
  input  logic [15:0] in_period_seconds,
  input  logic [15:0] in_repeat_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_ticks_per_second,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_timer_id_res,
  output logic        out_last
);

  localparam int IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FCW = $clog2(MAX_OUT);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  slot_t mem [NUM_SLOTS];
  slot_t rd_q;

  logic [NUM_SLOTS-1:0] valid_r;
  logic [NUM_SLOTS-1:0] due_r;
  logic [NUM_SLOTS-1:0] due_rest;
  logic [31:0]          now_r;
  logic [15:0]          tps_r;

  logic                 scanning_r;
  logic [IW-1:0]        cnt_r;
  logic                 pv_r;
  logic [IW-1:0]        pidx_r;
  scan_kind_t           kind_r;

  logic                 match_found_r;
  logic [IW-1:0]        match_idx_r;
  logic                 free_found_r;
  logic [IW-1:0]        free_idx_r;
  logic                 best_found_r;
  logic [IW-1:0]        best_idx_r;
  slot_t                best_ent_r;
  logic [FCW-1:0]       fire_cnt_r;

  logic [15:0]          id_r;
  logic [15:0]          reps_r;
  logic [31:0]          period_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [15:0]          out_id_r;
  logic                 out_last_r;

  logic                 hit;
  logic                 is_due;
  logic                 better;
  logic [31:0]          elapsed;
  logic                 fire_last;
  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  slot_t                wr_data;
  slot_t                fire_ent;

  assign cfg_ready = 1'b1;

  // compare on the slot read back in the previous cycle
  assign hit     = valid_r[pidx_r] && (rd_q.id == id_r);
  assign elapsed = now_r - rd_q.last_time;
  assign is_due  = valid_r[pidx_r] && (elapsed >= rd_q.period);
  assign better  = due_r[pidx_r] && (!best_found_r || (rd_q.id < best_ent_r.id));

  always_comb begin
    due_rest = due_r;
    due_rest[best_idx_r] = 1'b0;
  end

  assign fire_last = (fire_cnt_r == FCW'(MAX_OUT - 1)) || !(|due_rest);

  always_comb begin
    fire_ent = best_ent_r;
    fire_ent.last_time = now_r;
    if (best_ent_r.repeats > 16'd1) begin
      fire_ent.repeats = best_ent_r.repeats - 16'd1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = free_idx_r;
    wr_data = '{id: id_r, period: period_r, last_time: now_r, repeats: reps_r};
    if (cmd.do_set && free_found_r) begin
      wr_en = 1'b1;
    end else if (cmd.do_fire && best_found_r) begin
      wr_en   = 1'b1;
      wr_idx  = best_idx_r;
      wr_data = fire_ent;
    end
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (scanning_r) begin
      rd_q   <= mem[cnt_r];
      pidx_r <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      due_r         <= '0;
      now_r         <= '0;
      tps_r         <= TPS_RESET;
      scanning_r    <= 1'b0;
      cnt_r         <= '0;
      pv_r          <= 1'b0;
      kind_r        <= SK_MATCH;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      best_found_r  <= 1'b0;
      fire_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tps_r <= cfg_ticks_per_second;
      end
      if (cmd.advance) begin
        now_r <= now_r + 32'd1;
      end
      if (cmd.accept) begin
        fire_cnt_r <= '0;
      end

      pv_r <= scanning_r;
      if (cmd.scan_start) begin
        scanning_r    <= 1'b1;
        cnt_r         <= '0;
        kind_r        <= cmd.scan_kind;
        match_found_r <= 1'b0;
        free_found_r  <= 1'b0;
        best_found_r  <= 1'b0;
      end else if (scanning_r) begin
        if (cnt_r == LAST_IDX) begin
          scanning_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + IW'(1);
        end
      end

      if (pv_r) begin
        case (kind_r)
          SK_MATCH: begin
            if (hit) begin
              match_found_r <= 1'b1;
            end
            // first slot that is free once a same-id timer is dropped
            if (!free_found_r && (!valid_r[pidx_r] || hit)) begin
              free_found_r <= 1'b1;
            end
          end
          SK_DUE: begin
            due_r[pidx_r] <= is_due;
          end
          SK_PICK: begin
            if (better) begin
              best_found_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd.do_set && free_found_r) begin
        if (match_found_r) begin
          valid_r[match_idx_r] <= 1'b0;
        end
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.do_kill && match_found_r) begin
        valid_r[match_idx_r] <= 1'b0;
      end
      if (cmd.do_clear) begin
        valid_r <= '0;
      end
      if (cmd.do_fire && best_found_r) begin
        due_r[best_idx_r] <= 1'b0;
        if (best_ent_r.repeats == 16'd1) begin
          valid_r[best_idx_r] <= 1'b0;
        end
        fire_cnt_r <= fire_cnt_r + FCW'(1);
      end

      out_valid_r <= cmd.do_set | cmd.do_kill | cmd.do_clear | cmd.do_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_r     <= in_timer_id;
      reps_r   <= in_repeat_count;
      period_r <= {16'd0, in_period_seconds} * {16'd0, tps_r};
    end

    if (pv_r) begin
      case (kind_r)
        SK_MATCH: begin
          if (hit) begin
            match_idx_r <= pidx_r;
          end
          if (!free_found_r && (!valid_r[pidx_r] || hit)) begin
            free_idx_r <= pidx_r;
          end
        end
        SK_PICK: begin
          if (better) begin
            best_idx_r <= pidx_r;
            best_ent_r <= rd_q;
          end
        end
        default: ;
      endcase
    end

    if (cmd.do_set) begin
      out_status_r <= free_found_r ? ST_SET_OK : ST_FULL;
      out_id_r     <= id_r;
      out_last_r   <= 1'b1;
    end else if (cmd.do_kill) begin
      out_status_r <= match_found_r ? ST_KILLED : ST_NOT_FOUND;
      out_id_r     <= id_r;
      out_last_r   <= 1'b1;
    end else if (cmd.do_clear) begin
      out_status_r <= ST_CLEARED;
      out_id_r     <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.do_fire) begin
      if (best_found_r) begin
        out_status_r <= ST_FIRED;
        out_id_r     <= best_ent_r.id;
        out_last_r   <= fire_last;
      end else begin
        out_status_r <= ST_NONE_DUE;
        out_id_r     <= '0;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign sts.scan_done  = pv_r && (pidx_r == LAST_IDX);
  assign sts.best_found = best_found_r;
  assign sts.fire_last  = fire_last;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_timer_id_res = out_id_r;
  assign out_last         = out_last_r;

endmodule

// File: tb/multi_timer_table_test.sv
// ----------------------------------------------------------------------------
// multi_timer_table_test
// Self-checking bench for the timer table: set, kill, kill-all and tick.
// A cycle-free model of the table predicts the result beats of every accepted
// command, and a monitor compares each out_valid beat with the oldest one.
// Directed commands cover the empty and full table, id replacement, the
// repeat-count rules and ordering by id. Random commands then run under
// several tick-rate settings, with random sender gaps but for a last stretch.
// ----------------------------------------------------------------------------
module multi_timer_table_test import mtt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = NUM_SLOTS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int POOL_SIZE = 12;

  typedef struct {
    status_t     status;
    logic [15:0] id;
    logic        is_last;
  } timer_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [15:0] in_timer_id;
  logic [15:0] in_period_seconds;
  logic [15:0] in_repeat_count;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_timer_id_res;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_ticks_per_second;

  // model of the table
  logic        tbl_valid [NUM_SLOTS];
  logic [15:0] tbl_id [NUM_SLOTS];
  logic [31:0] tbl_period [NUM_SLOTS];
  logic [31:0] tbl_last [NUM_SLOTS];
  logic [15:0] tbl_repeats [NUM_SLOTS];
  logic [31:0] tbl_now;
  logic [15:0] tbl_tps;

  timer_result_t pending_results[$];
  logic [15:0]   id_pool [POOL_SIZE];
  int            error_count;
  int            stall_cycles;
  bit            gaps_on;

  multi_timer_table #(.NUM_SLOTS(NUM_SLOTS)) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_action            (in_action),
    .in_timer_id          (in_timer_id),
    .in_period_seconds    (in_period_seconds),
    .in_repeat_count      (in_repeat_count),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_timer_id_res     (out_timer_id_res),
    .out_last             (out_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ticks_per_second (cfg_ticks_per_second)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_timer(logic [15:0] tid);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_valid[i] && tbl_id[i] == tid) return i;
    end
    return -1;
  endfunction

  task automatic queue_result(status_t st, logic [15:0] tid, logic fin);
    timer_result_t r;
    r.status = st;
    r.id = tid;
    r.is_last = fin;
    pending_results.insert(pending_results.size(), r);
  endtask

  // predicts the result beats of one command and updates the table
  task automatic timer_table_apply(action_t act, logic [15:0] tid, logic [15:0] secs,
                                   logic [15:0] reps);
    int          slot;
    int          best;
    int          fired;
    logic        due [NUM_SLOTS];
    logic [15:0] fired_ids [MAX_OUT];
    case (act)
      ACT_SET: begin
        slot = find_timer(tid);
        if (slot >= 0) tbl_valid[slot] = 1'b0;
        slot = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) slot = i;
        end
        if (slot < 0) begin
          queue_result(ST_FULL, tid, 1'b1);
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_id[slot] = tid;
          tbl_period[slot] = 32'(secs) * 32'(tbl_tps);
          tbl_last[slot] = tbl_now;
          tbl_repeats[slot] = reps;
          queue_result(ST_SET_OK, tid, 1'b1);
        end
      end
      ACT_KILL: begin
        slot = find_timer(tid);
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          queue_result(ST_KILLED, tid, 1'b1);
        end else begin
          queue_result(ST_NOT_FOUND, tid, 1'b1);
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) tbl_valid[i] = 1'b0;
        queue_result(ST_CLEARED, 16'd0, 1'b1);
      end
      default: begin
        tbl_now = tbl_now + 32'd1;
        // elapsed time wraps, so compare the 32-bit difference
        for (int i = 0; i < NUM_SLOTS; i++) begin
          due[i] = tbl_valid[i] && ((tbl_now - tbl_last[i]) >= tbl_period[i]);
        end
        fired = 0;
        do begin
          best = -1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (due[i] && (best < 0 || tbl_id[i] < tbl_id[best])) best = i;
          end
          if (best >= 0) begin
            due[best] = 1'b0;
            tbl_last[best] = tbl_now;
            if (tbl_repeats[best] == 16'd1) tbl_valid[best] = 1'b0;
            else if (tbl_repeats[best] > 16'd1) tbl_repeats[best] = tbl_repeats[best] - 16'd1;
            fired_ids[fired] = tbl_id[best];
            fired++;
          end
        end while (best >= 0 && fired < MAX_OUT);
        if (fired == 0) begin
          queue_result(ST_NONE_DUE, 16'd0, 1'b1);
        end else begin
          for (int k = 0; k < fired; k++) queue_result(ST_FIRED, fired_ids[k], k == fired - 1);
        end
      end
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(action_t act, logic [15:0] tid, logic [15:0] secs,
                          logic [15:0] reps);
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    start = 1'b1;
    in_action = act;
    in_timer_id = tid;
    in_period_seconds = secs;
    in_repeat_count = reps;
    do @(posedge clk); while (busy);
    timer_table_apply(act, tid, secs, reps);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tps(logic [15:0] value);
    wait_all_results();
    cfg_valid = 1'b1;
    cfg_ticks_per_second = value;
    do @(posedge clk); while (!cfg_ready);
    tbl_tps = value;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_ticks_per_second = 16'($urandom);
  endtask

  // empty table, replacement by id, repeat counts and fire order at reset rate
  task automatic test_basic_commands();
    send_cmd(ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_KILL, 16'd5, 16'd0, 16'd0);
    send_cmd(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(ACT_SET, 16'd0, 16'd0, 16'd0);
    send_cmd(ACT_SET, 16'd7, 16'd0, 16'd1);
    send_cmd(ACT_SET, 16'd3, 16'd0, 16'd2);
    send_cmd(ACT_TICK, 16'd0, 16'd0, 16'd0);
    send_cmd(ACT_TICK, 16'd0, 16'd0, 16'd0);
    send_cmd(ACT_TICK, 16'd0, 16'd0, 16'd0);
    send_cmd(ACT_SET, 16'd0, 16'd0, 16'd3);
    send_cmd(ACT_KILL, 16'hFFFF, 16'd0, 16'd0);
    send_cmd(ACT_KILL, 16'hFFFF, 16'd0, 16'd0);
    send_cmd(ACT_CLEAR, 16'd0, 16'd0, 16'd0);
  endtask

  // fill every slot with ids in falling order, overflow, then one tick firing all and one with none due
  task automatic test_full_table();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_cmd(ACT_SET, 16'hFF00 - 16'(i * 257), 16'd0, 16'd1);
    end
    send_cmd(ACT_SET, 16'h1234, 16'd0, 16'd1);
    send_cmd(ACT_SET, 16'hFF00, 16'd0, 16'd1);
    send_cmd(ACT_TICK, 16'd0, 16'd0, 16'd0);
    send_cmd(ACT_TICK, 16'd0, 16'd0, 16'd0);
  endtask

  task automatic random_commands(int n_items);
    int          pick;
    logic [15:0] tid;
    logic [15:0] secs;
    logic [15:0] reps;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      tid = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                        : id_pool[$urandom_range(0, POOL_SIZE - 1)];
      secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      reps = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      if (pick < 35) send_cmd(ACT_SET, tid, secs, reps);
      else if (pick < 50) send_cmd(ACT_KILL, tid, secs, reps);
      else if (pick < 53) send_cmd(ACT_CLEAR, tid, secs, reps);
      else send_cmd(ACT_TICK, tid, secs, reps);
    end
  endtask

  task automatic test_random_rates();
    gaps_on = 1'b1;
    write_tps(16'd1);
    random_commands(50);
    write_tps(16'd2);
    random_commands(40);
    write_tps(16'hFFFF);
    random_commands(26);
    write_tps(16'($urandom_range(1, 5)));
    random_commands(40);
    // closing stretch back to back
    gaps_on = 1'b0;
    write_tps(16'd1);
    random_commands(40);
  endtask

  // result monitor: every beat must match the oldest prediction
  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d id %0h", out_status, out_timer_id_res);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_timer_id_res !== want.id) begin
          $error("timer_id_res: expected %0h, got %0h", want.id, out_timer_id_res);
          error_count++;
        end
        if (out_last !== want.is_last) begin
          $error("last: expected %0b, got %0b", want.is_last, out_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("multi_timer_table_test: errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_SET;
    in_timer_id = 16'd0;
    in_period_seconds = 16'd0;
    in_repeat_count = 16'd0;
    cfg_valid = 1'b0;
    cfg_ticks_per_second = 16'd0;
    error_count = 0;
    stall_cycles = 0;
    gaps_on = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) tbl_valid[i] = 1'b0;
    tbl_now = 32'd0;
    tbl_tps = TPS_RESET;
    id_pool[0] = 16'd0;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_commands();
    test_full_table();
    test_random_rates();

    wait_all_results();
    repeat (40) @(negedge clk);
    if (error_count == 0) begin
      $display("multi_timer_table_test: clean");
    end else begin
      $display("multi_timer_table_test: errors");
    end
    $finish;
  end

endmodule
